>>> sv/wpm_pkg.sv
package wpm_pkg;

    // Default pattern capacity in bytes
    localparam int PATTERN_MAX_DEF = 32;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_LOW_A = 8'h61;
    localparam logic [7:0] CH_LOW_Z = 8'h7A;
    localparam logic [7:0] CASE_GAP = 8'h20;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_CLEAR   = 2'd1,
        ACT_SUBJECT = 2'd2,
        ACT_END     = 2'd3
    } t_action;

    // Classified word, as handed from front to back
    typedef struct packed {
        t_action    op;
        logic [7:0] ch;        // case-folded byte
        logic       is_star;
        logic       is_quest;
        logic       is_nul;
    } t_cmd;

    function automatic logic [7:0] fold_case(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            r = c - CASE_GAP;
        end
        return r;
    endfunction

endpackage

>>> sv/wpm_front.sv
module wpm_front (
    input  logic             i_tvalid,
    input  logic [1:0]       i_tuser,
    input  logic [7:0]       i_tdata,
    output logic             o_push,
    output wpm_pkg::t_cmd    o_cmd
);

    always_comb begin
        o_cmd.op       = wpm_pkg::t_action'(i_tuser);
        o_cmd.ch       = wpm_pkg::fold_case(i_tdata);
        o_cmd.is_star  = (i_tdata == wpm_pkg::CH_STAR);
        o_cmd.is_quest = (i_tdata == wpm_pkg::CH_QUEST);
        o_cmd.is_nul   = (i_tdata == wpm_pkg::CH_NUL);
        // drop zero pattern bytes here; they never reach the back
        o_push = i_tvalid &&
                 !(o_cmd.op == wpm_pkg::ACT_APPEND && o_cmd.is_nul);
    end

endmodule

>>> sv/wpm_queue.sv
module wpm_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  wpm_pkg::t_cmd    i_cmd,
    output logic             o_ready,
    output logic             o_valid,
    output wpm_pkg::t_cmd    o_cmd,
    input  logic             i_pop
);

    localparam int DEPTH = wpm_pkg::QUEUE_DEPTH;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    wpm_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic          wr;
    logic          rd;

    assign o_ready = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign wr      = i_push && o_ready;
    assign rd      = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (rd && !wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

>>> sv/wpm_back.sv
module wpm_back #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cmd_valid,
    input  wpm_pkg::t_cmd    i_cmd,
    output logic             o_cmd_ready,
    output logic             o_m_tvalid,
    input  logic             i_m_tready,
    output logic             o_match,
    output logic             o_overflow
);

    localparam int W  = PATTERN_MAX + 1;
    localparam int LW = $clog2(W);

    logic [7:0]             r_pat_ch [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] r_pat_star;
    logic [PATTERN_MAX-1:0] r_pat_quest;
    logic [PATTERN_MAX-1:0] r_mask;
    logic [LW-1:0]          r_len;
    logic [W-1:0]           r_active;
    logic                   r_ovf;
    logic                   r_out_valid;
    logic                   r_match;
    logic                   r_out_ovf;

    logic [W-1:0]           star_v;
    logic [W-1:0]           closed;
    logic [PATTERN_MAX-1:0] adv;
    logic [PATTERN_MAX-1:0] stay;
    logic [W-1:0]           n_active;
    logic                   n_out_valid;
    logic                   full;
    logic                   pop;

    // Star closure as a carry chain: a carry started at an active star
    // runs through the following stars and lands one past the run.
    always_comb begin
        star_v = {1'b0, r_pat_star & r_mask};
        closed = r_active | ((star_v + (r_active & star_v)) ^ star_v);
        for (int i = 0; i < PATTERN_MAX; i++) begin
            stay[i] = closed[i] & r_mask[i] & r_pat_star[i];
            adv[i]  = closed[i] & r_mask[i] & ~r_pat_star[i] &
                      (r_pat_quest[i] | (r_pat_ch[i] == i_cmd.ch));
        end
        n_active = i_cmd.is_nul ? '0 : ({adv, 1'b0} | {1'b0, stay});
    end

    assign full        = (r_len == LW'(PATTERN_MAX));
    assign pop         = i_cmd_valid &&
                         (i_cmd.op != wpm_pkg::ACT_END || !r_out_valid || i_m_tready);
    assign n_out_valid = (pop && i_cmd.op == wpm_pkg::ACT_END) ||
                         (r_out_valid && !i_m_tready);
    assign o_cmd_ready = pop;
    assign o_m_tvalid  = r_out_valid;
    assign o_match     = r_match;
    assign o_overflow  = r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_mask      <= '0;
            r_active    <= W'(1);
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (pop) begin
                unique case (i_cmd.op)
                    wpm_pkg::ACT_APPEND: begin
                        if (!full) begin
                            r_len  <= r_len + 1'b1;
                            r_mask <= (r_mask << 1) | PATTERN_MAX'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                    end
                    wpm_pkg::ACT_CLEAR: begin
                        r_len    <= '0;
                        r_mask   <= '0;
                        r_ovf    <= 1'b0;
                        r_active <= W'(1);
                    end
                    wpm_pkg::ACT_SUBJECT: begin
                        r_active <= n_active;
                    end
                    wpm_pkg::ACT_END: begin
                        r_match     <= closed[r_len];
                        r_out_ovf   <= r_ovf;
                        r_active    <= W'(1);
                    end
                endcase
            end
        end
    end

    // Pattern cells: write the slot at the current length
    always_ff @(posedge i_clk) begin
        if (pop && i_cmd.op == wpm_pkg::ACT_APPEND && !full) begin
            for (int i = 0; i < PATTERN_MAX; i++) begin
                if (r_len == LW'(i)) begin
                    r_pat_ch[i]    <= i_cmd.ch;
                    r_pat_star[i]  <= i_cmd.is_star;
                    r_pat_quest[i] <= i_cmd.is_quest;
                end
            end
        end
    end

endmodule

>>> sv/wildcard_pattern_matcher_top.sv
// Wildcard pattern matcher ('*' any run, '?' any one byte, letters match
// regardless of case).
// Input stream: each word carries an action in i_s_tuser and a byte in
// i_s_tdata. Append words build the pattern one byte at a time (zero bytes
// are ignored, bytes past PATTERN_MAX are dropped and flagged), a clear
// word empties it, subject words stream the text to test, and an end word
// produces one result word and rearms for the next subject.
// Output stream: one word per end word, o_m_tdata bit 0 = match,
// bit 1 = pattern overflow since the last clear or reset.
// Throughput: one input word per cycle, sustained while no end word waits
// on a stalled output; the subject update is a bit-parallel step over all
// pattern positions (one carry chain of PATTERN_MAX+1 bits for star runs
// plus per-position compares). The result word passes through the front
// queue and is then registered by the engine.
// Reset: the pattern is empty, the overflow flag is clear, no result is
// pending, and the input is ready once reset is released.
// Stall: a stalled output holds its word; the queue keeps taking words
// until it fills, and only an end word waits on the output register.
module wildcard_pattern_matcher_top #(
    parameter int PATTERN_MAX = wpm_pkg::PATTERN_MAX_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] character
    input  logic [1:0] i_s_tuser,   // [1:0] action
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata    // [0] match, [1] pattern_overflow, [7:2] zero
);

    wpm_pkg::t_cmd front_cmd;
    wpm_pkg::t_cmd q_cmd;
    logic          front_push;
    logic          q_valid;
    logic          q_pop;
    logic          match;
    logic          overflow;

    // Classify the incoming word and fold its byte
    wpm_front u_front (
        .i_tvalid (i_s_tvalid),
        .i_tuser  (i_s_tuser),
        .i_tdata  (i_s_tdata),
        .o_push   (front_push),
        .o_cmd    (front_cmd)
    );

    // Decouple the front from the engine
    wpm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_ready (o_s_tready),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // Pattern store, active-position set and result register
    wpm_back #(
        .PATTERN_MAX (PATTERN_MAX)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_valid),
        .i_cmd       (q_cmd),
        .o_cmd_ready (q_pop),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_match     (match),
        .o_overflow  (overflow)
    );

    assign o_m_tdata = {6'b0, overflow, match};

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;

    localparam int PMAX           = wpm_pkg::PATTERN_MAX_DEF;
    localparam int STIM_WORDS     = 1400;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [PMAX:0] POS_ZERO = {{PMAX{1'b0}}, 1'b1};

    typedef struct {
        wpm_pkg::t_action act;
        logic [7:0]       ch;
    } t_word;

    typedef struct {
        logic match;
        logic ovf;
    } t_verdict;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_s_tvalid = 1'b0;
    logic       o_s_tready;
    logic [7:0] i_s_tdata = 8'h00;   // [7:0] character
    logic [1:0] i_s_tuser = 2'd0;    // [1:0] action
    logic       o_m_tvalid;
    logic       i_m_tready = 1'b0;
    logic [7:0] o_m_tdata;           // [0] match, [1] pattern_overflow, [7:2] zero

    wildcard_pattern_matcher_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #2 i_clk = ~i_clk;

    // Words waiting to be offered, and verdicts waiting to come out
    t_word    pending_words[$];
    t_verdict awaited_verdicts[$];
    int       errors = 0;
    int       idle_cycles = 0;

    // Shadow copy of the matcher state
    logic [7:0]  pat_bytes[PMAX];
    int          pat_len = 0;
    logic [PMAX:0] live_pos = POS_ZERO;
    logic        pat_ovf = 1'b0;

    // Pattern currently loaded by the stimulus generator (first PMAX bytes)
    logic [7:0] gen_pat[$];
    int         stim_count = 0;

    function automatic logic [7:0] upcase(input logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
    endfunction

    // Let every live position sitting on a star also reach the next one
    task automatic spread_stars();
        for (int i = 0; i < pat_len; i++) begin
            if (live_pos[i] && pat_bytes[i] == wpm_pkg::CH_STAR) begin
                live_pos[i + 1] = 1'b1;
            end
        end
    endtask

    // Advance the shadow matcher by one accepted word; queue a verdict on end
    task automatic advance_matcher(input wpm_pkg::t_action act, input logic [7:0] ch);
        logic [PMAX:0] nxt;
        case (act)
            wpm_pkg::ACT_APPEND: begin
                if (ch != wpm_pkg::CH_NUL) begin
                    if (pat_len < PMAX) begin
                        pat_bytes[pat_len] = ch;
                        pat_len++;
                    end else begin
                        pat_ovf = 1'b1;
                    end
                end
            end
            wpm_pkg::ACT_CLEAR: begin
                pat_len  = 0;
                pat_ovf  = 1'b0;
                live_pos = POS_ZERO;
            end
            wpm_pkg::ACT_SUBJECT: begin
                spread_stars();
                nxt = '0;
                if (ch != wpm_pkg::CH_NUL) begin
                    for (int i = 0; i < pat_len; i++) begin
                        if (live_pos[i]) begin
                            if (pat_bytes[i] == wpm_pkg::CH_STAR) begin
                                nxt[i] = 1'b1;
                            end else if (pat_bytes[i] == wpm_pkg::CH_QUEST ||
                                         upcase(pat_bytes[i]) == upcase(ch)) begin
                                nxt[i + 1] = 1'b1;
                            end
                        end
                    end
                end
                live_pos = nxt;
            end
            default: begin
                spread_stars();
                awaited_verdicts.push_back('{match: live_pos[pat_len], ovf: pat_ovf});
                live_pos = POS_ZERO;
            end
        endcase
    endtask

    // ---------------- stimulus generation ----------------

    task automatic send(input wpm_pkg::t_action act, input logic [7:0] ch);
        pending_words.push_back('{act: act, ch: ch});
        // zero appends are ignored by the block, so they do not count
        if (!(act == wpm_pkg::ACT_APPEND && ch == wpm_pkg::CH_NUL)) begin
            stim_count++;
        end
    endtask

    function automatic logic [7:0] pick_letter();
        logic [7:0] c;
        c = 8'h41 + 8'(int'($urandom_range(0, 2)));
        if ($urandom_range(0, 1) == 1) begin
            c = c | 8'h20;
        end
        return c;
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            return wpm_pkg::CH_STAR;
        end else if (r < 30) begin
            return wpm_pkg::CH_QUEST;
        end else if (r < 85) begin
            return pick_letter();
        end
        return 8'($urandom_range(1, 255));
    endfunction

    task automatic send_pattern(input int len);
        logic [7:0] c;
        gen_pat.delete();
        for (int i = 0; i < len; i++) begin
            c = pick_pattern_byte();
            if (gen_pat.size() < PMAX) begin
                gen_pat.push_back(c);
            end
            send(wpm_pkg::ACT_APPEND, c);
        end
    endtask

    // Build a subject from the loaded pattern, mostly matching, sometimes broken
    task automatic send_subject();
        logic [7:0] subj[$];
        logic [7:0] p;
        int         pos;
        foreach (gen_pat[i]) begin
            p = gen_pat[i];
            if (p == wpm_pkg::CH_STAR) begin
                repeat ($urandom_range(0, 3)) subj.push_back(pick_letter());
            end else if (p == wpm_pkg::CH_QUEST) begin
                subj.push_back(8'($urandom_range(1, 255)));
            end else if (upcase(p) >= 8'h41 && upcase(p) <= 8'h5A &&
                         $urandom_range(0, 1) == 1) begin
                subj.push_back(p ^ 8'h20);     // flip the letter case
            end else begin
                subj.push_back(p);
            end
        end
        if ($urandom_range(0, 9) < 3) begin
            pos = $urandom_range(0, subj.size());
            case ($urandom_range(0, 2))
                0: begin
                    if (pos < subj.size()) begin
                        subj[pos] = ($urandom_range(0, 3) == 0) ? wpm_pkg::CH_NUL
                                                                : 8'($urandom_range(0, 255));
                    end
                end
                1: subj.insert(pos, pick_letter());
                default: begin
                    if (pos < subj.size()) begin
                        subj.delete(pos);
                    end
                end
            endcase
        end
        foreach (subj[i]) begin
            send(wpm_pkg::ACT_SUBJECT, subj[i]);
        end
        send(wpm_pkg::ACT_END, 8'($urandom_range(0, 255)));
    endtask

    task automatic send_directed();
        send(wpm_pkg::ACT_END,     8'hFF);            // empty pattern, empty subject
        send(wpm_pkg::ACT_SUBJECT, 8'h78);
        send(wpm_pkg::ACT_END,     8'h00);            // empty pattern never eats a byte
        send(wpm_pkg::ACT_APPEND,  8'h61);
        send(wpm_pkg::ACT_APPEND,  wpm_pkg::CH_STAR);
        send(wpm_pkg::ACT_APPEND,  wpm_pkg::CH_QUEST);
        send(wpm_pkg::ACT_APPEND,  wpm_pkg::CH_NUL);  // zero pattern byte: dropped silently
        send(wpm_pkg::ACT_APPEND,  8'hFF);
        send(wpm_pkg::ACT_APPEND,  8'h5A);
        send(wpm_pkg::ACT_SUBJECT, 8'h41);            // case-folded letter
        send(wpm_pkg::ACT_SUBJECT, 8'h71);
        send(wpm_pkg::ACT_SUBJECT, 8'h80);
        send(wpm_pkg::ACT_SUBJECT, 8'hFF);
        send(wpm_pkg::ACT_SUBJECT, 8'h7A);
        send(wpm_pkg::ACT_END,     8'h55);
        send(wpm_pkg::ACT_SUBJECT, 8'h61);
        send(wpm_pkg::ACT_SUBJECT, wpm_pkg::CH_NUL);  // zero subject byte kills every position
        send(wpm_pkg::ACT_END,     8'hAA);
        send(wpm_pkg::ACT_CLEAR,   8'hFF);
        send(wpm_pkg::ACT_APPEND,  8'h40);            // '@' and '`' are not a case pair
        send(wpm_pkg::ACT_SUBJECT, 8'h60);
        send(wpm_pkg::ACT_END,     8'h01);
        send(wpm_pkg::ACT_SUBJECT, 8'h40);
        send(wpm_pkg::ACT_APPEND,  wpm_pkg::CH_STAR); // append in the middle of a subject
        send(wpm_pkg::ACT_END,     8'hFE);
    endtask

    task automatic send_random();
        int r;
        int len;
        while (stim_count < STIM_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 80) begin
                send(wpm_pkg::ACT_CLEAR, 8'($urandom_range(0, 255)));
                len = $urandom_range(0, 99);
                if (len < 5) begin
                    len = $urandom_range(PMAX + 1, PMAX + 8);   // overflow the store
                end else if (len < 15) begin
                    len = $urandom_range(16, PMAX);
                end else begin
                    len = $urandom_range(0, 8);
                end
                send_pattern(len);
                repeat ($urandom_range(1, 4)) send_subject();
            end else if (r < 90) begin
                // broken sequence: stray subject bytes, a late append, then end
                repeat ($urandom_range(0, 4)) send(wpm_pkg::ACT_SUBJECT, pick_letter());
                send(wpm_pkg::ACT_APPEND, pick_pattern_byte());
                repeat ($urandom_range(0, 3)) send(wpm_pkg::ACT_SUBJECT, pick_letter());
                send(wpm_pkg::ACT_END, 8'($urandom_range(0, 255)));
            end else begin
                repeat ($urandom_range(1, 6)) begin
                    send(wpm_pkg::t_action'($urandom_range(0, 3)),
                         8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // ---------------- reset and stimulus ----------------

    initial begin
        send_directed();
        send_random();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ---------------- sender: bursts with random gaps ----------------

    logic s_took = 1'b0;     // the word on the bus was taken at the last edge
    int   burst_left = 8;
    int   gap_left = 0;

    always @(negedge i_clk) begin
        t_word w;
        // advance only when the bus is free or its word was just taken
        if (i_rst_n && (!i_s_tvalid || s_took)) begin
            if (gap_left > 0) begin
                gap_left--;
                i_s_tvalid <= 1'b0;
            end else if (pending_words.size() > 0) begin
                w = pending_words.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= w.ch;
                i_s_tuser  <= w.act;
                burst_left--;
                if (burst_left <= 0) begin
                    if ($urandom_range(0, 9) == 0) begin
                        burst_left = 60;       // long stretch with no idling
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end
                end
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ---------------- receiver: stall pattern and long hold-offs ----------------

    int rcv_cycles = 0;
    int hold_left = 0;
    int mode = 0;
    int mode_left = 0;

    always @(negedge i_clk) begin
        logic r;
        rcv_cycles++;
        // hold off long enough for the block to back up and drop o_s_tready
        if (rcv_cycles == 300 || rcv_cycles % 1500 == 0) begin
            hold_left = $urandom_range(120, 200);
        end
        if (hold_left > 0) begin
            hold_left--;
            r = 1'b0;
        end else begin
            if (mode_left <= 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(10, 80);
            end
            mode_left--;
            case (mode)
                0: r = 1'b1;
                1: r = ($urandom_range(0, 1) == 1);
                2: r = ($urandom_range(0, 3) == 0);
                default: r = (rcv_cycles % 3 == 0);
            endcase
        end
        i_m_tready <= r;
    end

    // ---------------- monitor and prediction ----------------

    always @(posedge i_clk) begin
        t_verdict v;
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                if (awaited_verdicts.size() == 0) begin
                    $display("%0t: unexpected result word, got %h", $time, o_m_tdata);
                    errors++;
                end else begin
                    v = awaited_verdicts.pop_front();
                    if (o_m_tdata[0] !== v.match) begin
                        $display("%0t: match expected %b got %b", $time, v.match, o_m_tdata[0]);
                        errors++;
                    end
                    if (o_m_tdata[1] !== v.ovf) begin
                        $display("%0t: pattern_overflow expected %b got %b",
                                 $time, v.ovf, o_m_tdata[1]);
                        errors++;
                    end
                    if (o_m_tdata[7:2] !== 6'd0) begin
                        $display("%0t: pad bits expected 0 got %h", $time, o_m_tdata[7:2]);
                        errors++;
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                advance_matcher(wpm_pkg::t_action'(i_s_tuser), i_s_tdata);
            end
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        s_took <= i_rst_n && i_s_tvalid && o_s_tready;
    end

    // ---------------- watchdog ----------------

    initial begin
        while (idle_cycles < WATCHDOG_LIMIT) @(negedge i_clk);
        $display("FAIL wildcard_pattern_matcher_top");
        $finish;
    end

    // ---------------- end of run ----------------

    initial begin
        @(posedge i_rst_n);
        // check at the rising edge, where the sender's bus and queue are settled
        while (pending_words.size() > 0 || i_s_tvalid || awaited_verdicts.size() > 0) begin
            @(posedge i_clk);
        end
        // let any stray result word surface before judging
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        if (errors == 0) begin
            $display("PASS wildcard_pattern_matcher_top");
        end else begin
            $display("FAIL wildcard_pattern_matcher_top");
        end
        $finish;
    end

endmodule
